>>> rtl/min_stats_noise_tracker_assert.svh
// Assertion macros shared by the noise tracker RTL.
// No dependencies; each RTL file that checks itself includes this header.
`ifndef MIN_STATS_NOISE_TRACKER_ASSERT_SVH
`define MIN_STATS_NOISE_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define MST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mst: assertion failed");
// Next-cycle implication, disabled in reset.
`define MST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mst: assertion failed");
`else
`define MST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/mst_pkg.sv
// Shared types, constants and helpers of the minimum-statistics noise tracker.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none

package mst_pkg;

  // Store sizes; both are powers of two so a bin index and a slot pack into
  // one memory address.
  localparam int NUM_BINS       = 1024;
  localparam int MAX_SUBWINDOWS = 64;

  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int SLOT_W = $clog2(MAX_SUBWINDOWS);
  localparam int CNT_W  = $clog2(MAX_SUBWINDOWS + 1);
  localparam int SW_AW  = BIN_W + SLOT_W;

  // Field widths
  localparam int BIN_IDX_W = 10;
  localparam int POWER_W   = 32;
  localparam int PROB_W    = 16;
  localparam int COEF_W    = 16;
  localparam int FRAME_W   = 8;
  localparam int SWC_W     = 7;
  localparam int CMP_W     = (CNT_W > SWC_W) ? CNT_W : SWC_W;
  localparam int ALPHA_W   = COEF_W + 1;
  localparam int PROD_W    = ALPHA_W + POWER_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SMOOTHING   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_FLOOR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_SUBWIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBWINDOW_COUNT  = 3'd4;

  // Arithmetic constants (Q0.16 smoothing coefficients, Q4.12 bias gain, Q4.28 power)
  localparam logic [PROB_W-1:0]  PRESENCE_LIMIT = 16'd36044;
  localparam logic [COEF_W-1:0]  FAST_ALPHA     = 16'd62915;
  localparam logic [POWER_W-1:0] SEED_LEVEL     = 32'd27;
  localparam logic [POWER_W-1:0] FLOOR_RESET    = 32'd1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE      = 17'd65536;
  localparam logic [PROD_W-1:0]  ROUND_SMOOTH   = 49'd32768;
  localparam logic [PROD_W-1:0]  ROUND_EST      = 49'd2048;

  // Configuration register reset values
  localparam logic [COEF_W-1:0]  RST_SLOW_SMOOTHING = 16'd55705;
  localparam logic [COEF_W-1:0]  RST_BIAS_GAIN      = 16'd6144;
  localparam logic [FRAME_W-1:0] RST_FRAMES         = 8'd8;
  localparam logic [SWC_W-1:0]   RST_SUBWIN_COUNT   = 7'd36;

  typedef struct packed {
    logic [COEF_W-1:0]  slow_smoothing;
    logic [COEF_W-1:0]  bias_gain;
    logic [POWER_W-1:0] power_floor;
    logic [FRAME_W-1:0] frames_per_subwindow;
    logic [SWC_W-1:0]   subwindow_count;
  } cfg_t;

  // One row of per-bin state
  typedef struct packed {
    logic [POWER_W-1:0] smooth;
    logic [POWER_W-1:0] wmin;
    logic [POWER_W-1:0] gmin;
    logic [FRAME_W-1:0] frame;
    logic [SLOT_W-1:0]  ptr;
  } bin_row_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic rd_bin;
    logic mul_s;
    logic mul_p;
    logic sum;
    logic update;
    logic cnt_clr;
    logic fill_wr;
    logic rot_wr;
    logic scan_rd;
    logic est_mul;
    logic est_fin;
    logic wb;
    logic clear;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic seed;
    logic rotate;
    logic cnt_last;
    logic clr_done;
  } dp_sts_t;

  // Number of ring slots in use: zero counts as one, saturate at the maximum.
  function automatic logic [CNT_W-1:0] active_count(input logic [SWC_W-1:0] count);
    logic [CMP_W-1:0] c;
    c = CMP_W'(count);
    if (c == '0) begin
      active_count = CNT_W'(1);
    end else if (c > CMP_W'(MAX_SUBWINDOWS)) begin
      active_count = CNT_W'(MAX_SUBWINDOWS);
    end else begin
      active_count = CNT_W'(c);
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/mst_if.sv
// Valid/ready stream interfaces for the tracker's input and result channels.
// Depends on mst_pkg for field widths.
`default_nettype none

interface mst_in_if;
  logic                          valid;
  logic                          ready;
  logic [mst_pkg::BIN_IDX_W-1:0] bin_index;
  logic [mst_pkg::POWER_W-1:0]   bin_power;
  logic [mst_pkg::PROB_W-1:0]    presence_prob;

  modport source (output valid, output bin_index, output bin_power,
                  output presence_prob, input ready);
  modport sink   (input valid, input bin_index, input bin_power,
                  input presence_prob, output ready);
endinterface

interface mst_out_if;
  logic                        valid;
  logic                        ready;
  logic [mst_pkg::POWER_W-1:0] noise_estimate;
  logic [mst_pkg::POWER_W-1:0] smoothed_power;

  modport source (output valid, output noise_estimate, output smoothed_power,
                  input ready);
  modport sink   (input valid, input noise_estimate, input smoothed_power,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/mst_ctrl.sv
// Sequencer of the noise tracker: runs the clearing sweep after reset, then steps one beat through
// read, smoothing, seeding, ring rotation, minimum scan and estimate. Depends on mst_pkg.
`default_nettype none
`include "min_stats_noise_tracker_assert.svh"

module mst_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  mst_pkg::dp_sts_t sts,
  input  logic             in_valid,
  input  logic             out_free,
  output mst_pkg::dp_cmd_t cmd,
  output logic             in_ready,
  output logic             out_load
);

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_READ     = 14'b00000000000100,
    S_MUL_S    = 14'b00000000001000,
    S_MUL_P    = 14'b00000000010000,
    S_SUM      = 14'b00000000100000,
    S_UPDATE   = 14'b00000001000000,
    S_FILL     = 14'b00000010000000,
    S_ROT      = 14'b00000100000000,
    S_SCAN     = 14'b00001000000000,
    S_SCAN_END = 14'b00010000000000,
    S_EST_MUL  = 14'b00100000000000,
    S_EST_FIN  = 14'b01000000000000,
    S_DONE     = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = 1'b1;
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd_bin = 1'b1;
        state_nxt  = S_MUL_S;
      end
      S_MUL_S: begin
        cmd.mul_s = 1'b1;
        state_nxt = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.mul_p = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update  = 1'b1;
        cmd.cnt_clr = 1'b1;
        if (sts.seed) begin
          state_nxt = S_FILL;
        end else if (sts.rotate) begin
          state_nxt = S_ROT;
        end else begin
          state_nxt = S_EST_MUL;
        end
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.cnt_last) state_nxt = sts.rotate ? S_ROT : S_EST_MUL;
      end
      S_ROT: begin
        cmd.rot_wr  = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.cnt_last) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: begin
        state_nxt = S_EST_MUL;
      end
      S_EST_MUL: begin
        cmd.est_mul = 1'b1;
        state_nxt   = S_EST_FIN;
      end
      S_EST_FIN: begin
        cmd.est_fin = 1'b1;
        cmd.wb      = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // hold the finished result until the output register is free
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `MST_ASSERT_IMP(a_load_when_free, clk, rst_n, out_load, out_free)
  `MST_ASSERT_IMP(a_clear_blocks_input, clk, rst_n, state_r == S_CLEAR, !in_ready && !out_load)

endmodule

`default_nettype wire

>>> rtl/mst_dp.sv
// Datapath of the noise tracker: per-bin state memory, sub-window minima
// memory, shared multiplier, minimum tracking and estimate. Depends on mst_pkg.
`default_nettype none
`include "min_stats_noise_tracker_assert.svh"

module mst_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mst_pkg::cfg_t                 cfg,
  input  mst_pkg::dp_cmd_t              cmd,
  output mst_pkg::dp_sts_t              sts,
  input  logic [mst_pkg::BIN_IDX_W-1:0] in_bin_index,
  input  logic [mst_pkg::POWER_W-1:0]   in_bin_power,
  input  logic [mst_pkg::PROB_W-1:0]    in_presence_prob,
  output logic [mst_pkg::POWER_W-1:0]   est,
  output logic [mst_pkg::POWER_W-1:0]   smoothed
);

  localparam int BIN_W   = mst_pkg::BIN_W;
  localparam int SLOT_W  = mst_pkg::SLOT_W;
  localparam int CNT_W   = mst_pkg::CNT_W;
  localparam int SW_AW   = mst_pkg::SW_AW;
  localparam int POWER_W = mst_pkg::POWER_W;
  localparam int PROB_W  = mst_pkg::PROB_W;
  localparam int FRAME_W = mst_pkg::FRAME_W;
  localparam int ALPHA_W = mst_pkg::ALPHA_W;
  localparam int PROD_W  = mst_pkg::PROD_W;

  // Beat fields
  logic [BIN_W-1:0]   bin_r;
  logic [POWER_W-1:0] power_r;
  logic [PROB_W-1:0]  pres_r;

  // Working state of the bin
  mst_pkg::bin_row_t  row_rd_r;
  logic [POWER_W-1:0] sw_rd_r;
  logic [POWER_W-1:0] sw0_r;
  logic [POWER_W-1:0] s_r;
  logic [POWER_W-1:0] wmin_r;
  logic [POWER_W-1:0] gmin_r;
  logic [FRAME_W-1:0] frame_r;
  logic [SLOT_W-1:0]  ptr_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  part_r;
  logic [POWER_W-1:0] est_r;
  logic [SLOT_W-1:0]  j_r;
  logic [SW_AW-1:0]   clr_r;
  logic               scan_vld_r;
  logic               scan_first_r;

  // Memories
  mst_pkg::bin_row_t  bin_mem [2**BIN_W];
  logic [POWER_W-1:0] sw_mem  [2**SW_AW];

  // Smoothing coefficient from presence
  logic [ALPHA_W-1:0] alpha;
  logic [ALPHA_W-1:0] om_alpha;
  assign alpha    = (pres_r > mst_pkg::PRESENCE_LIMIT) ? {1'b0, mst_pkg::FAST_ALPHA}
                                                      : {1'b0, cfg.slow_smoothing};
  assign om_alpha = mst_pkg::ALPHA_ONE - alpha;

  // Floored global minimum
  logic [POWER_W-1:0] gfl;
  assign gfl = (gmin_r < cfg.power_floor) ? cfg.power_floor : gmin_r;

  // Shared multiplier operand select
  logic [ALPHA_W-1:0] mul_a;
  logic [POWER_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_c;
  always_comb begin
    if (cmd.mul_s) begin
      mul_a = alpha;
      mul_b = row_rd_r.smooth;
    end else if (cmd.mul_p) begin
      mul_a = om_alpha;
      mul_b = power_r;
    end else begin
      mul_a = {1'b0, cfg.bias_gain};
      mul_b = gfl;
    end
  end
  assign prod_c = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Smoothing sum and rounded estimate
  logic [PROD_W-1:0] sum_c;
  logic [PROD_W-1:0] est_c;
  assign sum_c = part_r + prod_r + mst_pkg::ROUND_SMOOTH;
  assign est_c = prod_r + mst_pkg::ROUND_EST;

  // Seed, rotation and ring pointer decisions
  logic               seed_c;
  logic               rot_c;
  logic [CNT_W-1:0]   d_eff;
  logic [SLOT_W-1:0]  dm1;
  logic [SLOT_W-1:0]  ptr_eff;
  logic [CNT_W-1:0]   ptr_inc;
  logic [SLOT_W-1:0]  ptr_nxt;
  logic [FRAME_W-1:0] frame_wb;
  assign seed_c   = (sw0_r <= mst_pkg::SEED_LEVEL) && (s_r > mst_pkg::SEED_LEVEL);
  assign rot_c    = ({1'b0, frame_r} + 9'd1) >= {1'b0, cfg.frames_per_subwindow};
  assign d_eff    = mst_pkg::active_count(cfg.subwindow_count);
  assign dm1      = SLOT_W'(d_eff - CNT_W'(1));
  assign ptr_eff  = (CNT_W'(ptr_r) >= CNT_W'(mst_pkg::MAX_SUBWINDOWS)) ? '0 : ptr_r;
  assign ptr_inc  = CNT_W'(ptr_eff) + CNT_W'(1);
  assign ptr_nxt  = (ptr_inc >= d_eff) ? '0 : SLOT_W'(ptr_inc);
  assign frame_wb = rot_c ? '0 : frame_r + FRAME_W'(1);

  assign sts.seed     = seed_c;
  assign sts.rotate   = rot_c;
  assign sts.cnt_last = (j_r == dm1);
  assign sts.clr_done = &clr_r;

  // Latch beat fields
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      bin_r   <= BIN_W'(in_bin_index);
      power_r <= in_bin_power;
      pres_r  <= in_presence_prob;
    end
  end

  // Multiplier and sum registers
  always_ff @(posedge clk) begin
    if (cmd.mul_s || cmd.mul_p || cmd.est_mul) prod_r <= prod_c;
    if (cmd.mul_p) part_r <= prod_r;
    if (cmd.sum) s_r <= sum_c[POWER_W+15:16];
    if (cmd.est_fin) est_r <= (|est_c[PROD_W-1:44]) ? '1 : est_c[43:12];
  end

  // Capture bin state, then track minima
  always_ff @(posedge clk) begin
    if (cmd.mul_s) begin
      wmin_r  <= row_rd_r.wmin;
      frame_r <= row_rd_r.frame;
      ptr_r   <= row_rd_r.ptr;
      sw0_r   <= sw_rd_r;
    end else if (cmd.update) begin
      if (seed_c || (s_r < wmin_r)) wmin_r <= s_r;
    end else if (cmd.rot_wr) begin
      wmin_r <= s_r;
      ptr_r  <= ptr_nxt;
    end

    if (cmd.mul_s) begin
      gmin_r <= row_rd_r.gmin;
    end else if (cmd.update && seed_c) begin
      gmin_r <= s_r;
    end else if (scan_vld_r) begin
      if (scan_first_r || (sw_rd_r < gmin_r)) gmin_r <= sw_rd_r;
    end
  end

  // Slot counter for seeding fill and minimum scan
  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      j_r <= '0;
    end else if (cmd.fill_wr || cmd.scan_rd) begin
      j_r <= j_r + SLOT_W'(1);
    end
  end

  // Scan read pipeline and clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r   <= 1'b0;
      scan_first_r <= 1'b0;
      clr_r        <= '0;
    end else begin
      scan_vld_r   <= cmd.scan_rd;
      scan_first_r <= cmd.scan_rd && (j_r == '0);
      if (cmd.clear) clr_r <= clr_r + SW_AW'(1);
    end
  end

  // Per-bin state memory
  mst_pkg::bin_row_t bin_wdata;
  logic [BIN_W-1:0]  bin_waddr;
  always_comb begin
    if (cmd.clear) begin
      bin_waddr = clr_r[SW_AW-1 -: BIN_W];
      bin_wdata = '{smooth: mst_pkg::FLOOR_RESET, wmin: mst_pkg::FLOOR_RESET,
                    gmin: mst_pkg::FLOOR_RESET, frame: '0, ptr: '0};
    end else begin
      bin_waddr = bin_r;
      bin_wdata = '{smooth: s_r, wmin: wmin_r, gmin: gmin_r, frame: frame_wb, ptr: ptr_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear || cmd.wb) bin_mem[bin_waddr] <= bin_wdata;
    if (cmd.rd_bin) row_rd_r <= bin_mem[bin_r];
  end

  // Sub-window minima memory
  logic [SW_AW-1:0]   sw_waddr;
  logic [POWER_W-1:0] sw_wdata;
  logic [SW_AW-1:0]   sw_raddr;
  always_comb begin
    if (cmd.clear) begin
      sw_waddr = clr_r;
      sw_wdata = mst_pkg::FLOOR_RESET;
    end else if (cmd.fill_wr) begin
      sw_waddr = {bin_r, j_r};
      sw_wdata = s_r;
    end else begin
      sw_waddr = {bin_r, ptr_eff};
      sw_wdata = wmin_r;
    end
    sw_raddr = cmd.scan_rd ? {bin_r, j_r} : {bin_r, SLOT_W'(0)};
  end

  always_ff @(posedge clk) begin
    if (cmd.clear || cmd.fill_wr || cmd.rot_wr) sw_mem[sw_waddr] <= sw_wdata;
    if (cmd.rd_bin || cmd.scan_rd) sw_rd_r <= sw_mem[sw_raddr];
  end

  assign est      = est_r;
  assign smoothed = s_r;

  `MST_ASSERT_NXT(a_ptr_in_ring, clk, rst_n, cmd.rot_wr, CNT_W'(ptr_r) < d_eff)
  `MST_ASSERT_NXT(a_seed_sets_minima, clk, rst_n, cmd.update && seed_c, wmin_r == s_r && gmin_r == s_r)

endmodule

`default_nettype wire

>>> rtl/min_stats_noise_tracker.sv
// Top level of the minimum-statistics noise tracker: configuration registers,
// output register, sequencer and datapath. Depends on mst_pkg, mst_if,
// mst_ctrl and mst_dp.
//
//  channel | dir | handshake        | payload
//  in_if   | in  | valid / ready    | bin_index, bin_power, presence_prob
//  out_if  | out | valid / ready    | noise_estimate, smoothed_power
//  cfg_*   | in  | cfg_we (no wait) | cfg_idx, cfg_wdata
//
// One beat is in work at a time. A beat takes longer when the sub-window ring
// rotates (minimum scan through the single read port of the minima memory)
// and when the bin is seeded (fill of every ring slot in use).
// After reset a clearing sweep writes all 65536 minima entries (one a cycle)
// and the per-bin rows; no beat is accepted until it ends.
// A result waits in the output register; a stalled result holds the next
// finished beat in the datapath until the register frees.
`default_nettype none
`include "min_stats_noise_tracker_assert.svh"

module min_stats_noise_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  mst_in_if.sink                        in_if,
  mst_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [mst_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [mst_pkg::POWER_W-1:0]   cfg_wdata
);

  localparam int POWER_W = mst_pkg::POWER_W;

  mst_pkg::cfg_t      cfg_r;
  mst_pkg::dp_cmd_t   cmd;
  mst_pkg::dp_sts_t   sts;
  logic               in_ready;
  logic               out_load;
  logic               out_free;
  logic               out_valid_r;
  logic [POWER_W-1:0] out_est_r;
  logic [POWER_W-1:0] out_smooth_r;
  logic [POWER_W-1:0] dp_est;
  logic [POWER_W-1:0] dp_smooth;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_smoothing       <= mst_pkg::RST_SLOW_SMOOTHING;
      cfg_r.bias_gain            <= mst_pkg::RST_BIAS_GAIN;
      cfg_r.power_floor          <= mst_pkg::FLOOR_RESET;
      cfg_r.frames_per_subwindow <= mst_pkg::RST_FRAMES;
      cfg_r.subwindow_count      <= mst_pkg::RST_SUBWIN_COUNT;
    end else if (cfg_we) begin
      case (cfg_idx)
        mst_pkg::CFG_SLOW_SMOOTHING:    cfg_r.slow_smoothing <= cfg_wdata[15:0];
        mst_pkg::CFG_BIAS_GAIN:         cfg_r.bias_gain <= cfg_wdata[15:0];
        mst_pkg::CFG_POWER_FLOOR:       cfg_r.power_floor <= cfg_wdata;
        mst_pkg::CFG_FRAMES_PER_SUBWIN: cfg_r.frames_per_subwindow <= cfg_wdata[7:0];
        mst_pkg::CFG_SUBWINDOW_COUNT:   cfg_r.subwindow_count <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  mst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .in_valid (in_if.valid),
    .out_free (out_free),
    .cmd      (cmd),
    .in_ready (in_ready),
    .out_load (out_load)
  );

  mst_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_bin_index     (in_if.bin_index),
    .in_bin_power     (in_if.bin_power),
    .in_presence_prob (in_if.presence_prob),
    .est              (dp_est),
    .smoothed         (dp_smooth)
  );

  assign in_if.ready = in_ready;

  // Output register: load a finished beat, drop it once taken
  assign out_free = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_est_r    <= dp_est;
      out_smooth_r <= dp_smooth;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.noise_estimate = out_est_r;
  assign out_if.smoothed_power = out_smooth_r;

  `MST_ASSERT_NXT(a_one_beat_in_work, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready)

endmodule

`default_nettype wire

>>> sim/tb_min_stats_noise_tracker.sv
// Self-checking testbench of the minimum-statistics noise tracker.
// Depends on mst_pkg, the stream interfaces in mst_if and the top level RTL.
// Beats from a queue go in under random idling; results are checked against a bin-level predictor.
`timescale 1ns / 1ps

module tb_min_stats_noise_tracker;

  localparam int BIN_IDX_W      = mst_pkg::BIN_IDX_W;
  localparam int POWER_W        = mst_pkg::POWER_W;
  localparam int PROB_W         = mst_pkg::PROB_W;
  localparam int CFG_IDX_W      = mst_pkg::CFG_IDX_W;
  localparam int COEF_W         = mst_pkg::COEF_W;
  localparam int FRAME_W        = mst_pkg::FRAME_W;
  localparam int SWC_W          = mst_pkg::SWC_W;
  localparam int SLOT_W         = mst_pkg::SLOT_W;
  localparam int ALPHA_W        = mst_pkg::ALPHA_W;
  localparam int NUM_BINS       = mst_pkg::NUM_BINS;
  localparam int MAX_SUBWINDOWS = mst_pkg::MAX_SUBWINDOWS;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 200;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_BEATS = 72;

  typedef struct {
    logic [BIN_IDX_W-1:0] bin;
    logic [POWER_W-1:0]   power;
    logic [PROB_W-1:0]    prob;
  } bin_beat_t;

  typedef struct {
    logic [POWER_W-1:0] noise;
    logic [POWER_W-1:0] smooth;
  } noise_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [POWER_W-1:0] cfg_wdata;

  mst_in_if  in_ch ();
  mst_out_if out_ch ();

  min_stats_noise_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Register mirror
  logic [COEF_W-1:0]  cfg_slow;
  logic [COEF_W-1:0]  cfg_bias;
  logic [POWER_W-1:0] cfg_floor;
  logic [FRAME_W-1:0] cfg_frames;
  logic [SWC_W-1:0]   cfg_count;

  // Per-bin tracker state of the predictor
  logic [POWER_W-1:0] smooth_mem [NUM_BINS];
  logic [POWER_W-1:0] wmin_mem   [NUM_BINS];
  logic [POWER_W-1:0] gmin_mem   [NUM_BINS];
  logic [FRAME_W-1:0] frame_mem  [NUM_BINS];
  logic [SLOT_W-1:0]  ring_mem   [NUM_BINS];
  logic [POWER_W-1:0] minima_mem [NUM_BINS][MAX_SUBWINDOWS];

  bin_beat_t     beats_to_send [$];
  noise_result_t expected_results [$];

  int queued_count;
  int accepted_count;
  int error_count;
  int cycle_count;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  bit in_taken;
  logic [BIN_IDX_W-1:0] hot_bins [4];

  // Advance one bin by one frame and return its noise estimate
  function automatic noise_result_t track_bin(input bin_beat_t beat);
    noise_result_t r;
    logic [ALPHA_W-1:0] alpha;
    logic [63:0] acc;
    logic [63:0] est;
    logic [POWER_W-1:0] s;
    logic [POWER_W-1:0] g;
    int unsigned d;
    int unsigned ptr;
    int b;
    int j;
    b = int'(beat.bin);
    d = int'(cfg_count);
    if (d == 0) d = 1;
    if (d > MAX_SUBWINDOWS) d = MAX_SUBWINDOWS;
    alpha = (beat.prob > mst_pkg::PRESENCE_LIMIT) ? ALPHA_W'(mst_pkg::FAST_ALPHA)
                                                  : ALPHA_W'(cfg_slow);
    acc = 64'(alpha) * 64'(smooth_mem[b])
          + 64'(mst_pkg::ALPHA_ONE - alpha) * 64'(beat.power) + 64'd32768;
    s = acc[47:16];
    smooth_mem[b] = s;

    // seed the whole ring the first time the bin carries signal
    if (minima_mem[b][0] <= mst_pkg::SEED_LEVEL && s > mst_pkg::SEED_LEVEL) begin
      for (j = 0; j < d; j++) minima_mem[b][j] = s;
      gmin_mem[b] = s;
      wmin_mem[b] = s;
    end
    if (s < wmin_mem[b]) wmin_mem[b] = s;

    // close the sub-window: store its minimum, advance the ring, rescan
    if (int'(frame_mem[b]) + 1 >= int'(cfg_frames)) begin
      ptr = int'(ring_mem[b]);
      minima_mem[b][ptr] = wmin_mem[b];
      ring_mem[b] = (ptr + 1 >= d) ? '0 : SLOT_W'(ptr + 1);
      wmin_mem[b] = s;
      frame_mem[b] = '0;
      g = minima_mem[b][0];
      for (j = 1; j < d; j++) begin
        if (minima_mem[b][j] < g) g = minima_mem[b][j];
      end
      gmin_mem[b] = g;
    end else begin
      frame_mem[b] = frame_mem[b] + 1'b1;
    end

    g = gmin_mem[b];
    if (g < cfg_floor) g = cfg_floor;
    est = (64'(cfg_bias) * 64'(g) + 64'd2048) >> 12;
    if (est > 64'hFFFF_FFFF) est = 64'hFFFF_FFFF;
    r.noise = est[31:0];
    r.smooth = s;
    return r;
  endfunction

  task automatic flag_error(input string what, input logic [31:0] want, input logic [31:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch, %s: expected %h, got %h", what, want, got);
  endtask

  task automatic push_beat(input logic [31:0] bin, input logic [31:0] power,
                           input logic [31:0] prob);
    bin_beat_t beat;
    beat.bin = bin[BIN_IDX_W-1:0];
    beat.power = power;
    beat.prob = prob[PROB_W-1:0];
    beats_to_send.insert(beats_to_send.size(), beat);
    queued_count++;
  endtask

  // Mostly frames of a few hot bins, the rest scattered noise
  task automatic push_random(input int n);
    logic [31:0] bin;
    logic [31:0] power;
    logic [31:0] prob;
    repeat (n) begin
      bin = ($urandom_range(99) < 80) ? 32'(hot_bins[$urandom_range(3)]) : $urandom;
      case ($urandom_range(2))
        0: power = $urandom;
        1: power = $urandom_range(63);
        default: power = $urandom & 32'h00FF_FFFF;
      endcase
      case ($urandom_range(2))
        0: prob = $urandom;
        1: prob = $urandom_range(65535, 36045);
        default: prob = $urandom_range(36050, 36038);
      endcase
      push_beat(bin, power, prob);
    end
  endtask

  task automatic pick_hot_bins();
    int k;
    for (k = 0; k < 4; k++) hot_bins[k] = BIN_IDX_W'($urandom);
  endtask

  task automatic wait_drained();
    while (accepted_count != queued_count || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      mst_pkg::CFG_SLOW_SMOOTHING:    cfg_slow = data[COEF_W-1:0];
      mst_pkg::CFG_BIAS_GAIN:         cfg_bias = data[COEF_W-1:0];
      mst_pkg::CFG_POWER_FLOOR:       cfg_floor = data;
      mst_pkg::CFG_FRAMES_PER_SUBWIN: cfg_frames = data[FRAME_W-1:0];
      mst_pkg::CFG_SUBWINDOW_COUNT:   cfg_count = data[SWC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [31:0] slow, input logic [31:0] bias,
                              input logic [31:0] floor_val, input logic [31:0] frames,
                              input logic [31:0] count);
    write_reg(mst_pkg::CFG_SLOW_SMOOTHING, slow);
    write_reg(mst_pkg::CFG_BIAS_GAIN, bias);
    write_reg(mst_pkg::CFG_POWER_FLOOR, floor_val);
    write_reg(mst_pkg::CFG_FRAMES_PER_SUBWIN, frames);
    write_reg(mst_pkg::CFG_SUBWINDOW_COUNT, count);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[min_stats_noise_tracker] ERROR");
    $finish;
  end

  // Drive input beats; hold a beat until it is taken
  always @(negedge clk) begin : drive_input
    bin_beat_t beat;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        beat = beats_to_send.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.bin_index <= beat.bin;
        in_ch.bin_power <= beat.power;
        in_ch.presence_prob <= beat.prob;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check result beats first, then predict for the accepted input beat
  always @(posedge clk) begin : watch_beats
    noise_result_t want;
    bin_beat_t beat;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        flag_error("result with nothing pending", '0, out_ch.noise_estimate);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.noise_estimate !== want.noise)
          flag_error("noise_estimate", want.noise, out_ch.noise_estimate);
        if (out_ch.smoothed_power !== want.smooth)
          flag_error("smoothed_power", want.smooth, out_ch.smoothed_power);
      end
    end
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      beat.bin = in_ch.bin_index;
      beat.power = in_ch.bin_power;
      beat.prob = in_ch.presence_prob;
      expected_results.insert(expected_results.size(), track_bin(beat));
      accepted_count++;
    end
  end

  // Stimulus sequence
  initial begin
    int b;
    int j;
    int k;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.bin_index = '0;
    in_ch.bin_power = '0;
    in_ch.presence_prob = '0;
    out_ch.ready = 1'b0;
    queued_count = 0;
    accepted_count = 0;
    error_count = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    in_taken = 1'b0;
    tx_idle_pct = 31;
    rx_idle_pct = 77;
    cfg_slow = mst_pkg::RST_SLOW_SMOOTHING;
    cfg_bias = mst_pkg::RST_BIAS_GAIN;
    cfg_floor = mst_pkg::FLOOR_RESET;
    cfg_frames = mst_pkg::RST_FRAMES;
    cfg_count = mst_pkg::RST_SUBWIN_COUNT;
    for (b = 0; b < NUM_BINS; b++) begin
      smooth_mem[b] = mst_pkg::FLOOR_RESET;
      wmin_mem[b] = mst_pkg::FLOOR_RESET;
      gmin_mem[b] = mst_pkg::FLOOR_RESET;
      frame_mem[b] = '0;
      ring_mem[b] = '0;
      for (j = 0; j < MAX_SUBWINDOWS; j++) minima_mem[b][j] = mst_pkg::FLOOR_RESET;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, presence edge, seed edge, one full sub-window
    push_beat(0, 0, 0);
    push_beat(1023, 32'hFFFF_FFFF, 16'hFFFF);
    push_beat(0, 32'hFFFF_FFFF, 36044);
    push_beat(0, 0, 36045);
    push_beat(5, 27, 0);
    push_beat(5, 28, 16'hFFFF);
    for (k = 0; k < 10; k++)
      push_beat(2, (k < 6) ? (32'h0800_0000 >> k) : (32'h0040_0000 << (k - 6)),
                (k % 2) ? 16'hFFFF : 16'h0000);
    push_beat(512, 32'h5555_5555, 16'hAAAA);
    push_beat(341, 32'hAAAA_AAAA, 16'h5555);
    wait_drained();

    // Reset settings
    pick_hot_bins();
    push_random(PHASE_BEATS);
    wait_drained();

    // Low extremes: zero slow smoothing and no floor; two-frame sub-windows, four slots
    apply_config(0, 16'hFFFF, 0, 2, 4);
    pick_hot_bins();
    push_random(PHASE_BEATS);
    wait_drained();

    // High extremes, with the result side held off for a long stretch
    tx_idle_pct = 77;
    rx_idle_pct = 31;
    apply_config(16'hFFFF, 0, 1000, 255, 64);
    pick_hot_bins();
    push_random(PHASE_BEATS);
    hold_req++;
    wait_drained();

    // Zero count and zero length; the sender pauses halfway until all results are in
    apply_config($urandom, $urandom, 32'hFFFF_FFFF, 0, 0);
    pick_hot_bins();
    push_random(PHASE_BEATS / 2);
    wait_drained();
    push_random(PHASE_BEATS / 2);
    wait_drained();

    // Count past the ring size, length one, no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_config(mst_pkg::RST_SLOW_SMOOTHING, mst_pkg::RST_BIAS_GAIN,
                 mst_pkg::FLOOR_RESET, 1, 127);
    pick_hot_bins();
    push_random(PHASE_BEATS);
    wait_drained();

    // Random in-range settings
    apply_config($urandom, $urandom_range(8191), $urandom_range(4095),
                 $urandom_range(20, 2), $urandom_range(64, 4));
    pick_hot_bins();
    push_random(PHASE_BEATS);
    wait_drained();

    // Let any stray result show up
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_results.size() != 0)
      flag_error("results never seen", expected_results.size(), 0);
    if (error_count == 0) begin
      $display("[min_stats_noise_tracker] OK");
    end else begin
      $display("[min_stats_noise_tracker] ERROR");
    end
    $finish;
  end

endmodule
